### hdl/qmv_pkg.sv
// package: shared constants, types and register codes of the q15 matrix-vector multiply
`timescale 1ns / 1ps
package qmv_pkg;

	localparam int LANES          = 8;
	localparam int LANE_W         = 16;
	localparam int CHUNKS_MAX     = 16;
	localparam int CHUNK_IDX_W    = $clog2(CHUNKS_MAX);
	localparam int ROWS_MAX       = 32;
	localparam int ROW_W          = $clog2(ROWS_MAX);
	localparam int CHUNKS_CFG_W   = 5;
	localparam int ROWS_CFG_W     = 6;
	localparam int FRACTION_SHIFT = 15;
	localparam int PROD_W         = 2 * LANE_W;
	localparam int SUM_W          = PROD_W + $clog2(LANES);
	localparam int ACC_W          = 40;
	localparam int RES_MAX        = 32767;
	localparam int RES_MIN        = -32768;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_PER_ROW = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_TILE  = CFG_IDX_W'(1);

	localparam logic [CHUNKS_CFG_W-1:0] CHUNKS_RESET = CHUNKS_CFG_W'(16);
	localparam logic [ROWS_CFG_W-1:0]   ROWS_RESET   = ROWS_CFG_W'(32);

	typedef logic signed [LANE_W-1:0] lane_t;
	typedef logic [LANES-1:0][LANE_W-1:0] chunk_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic [CHUNKS_CFG_W-1:0] chunks_per_row;
		logic [ROWS_CFG_W-1:0]   rows_per_tile;
	} cfg_t;

	typedef struct packed {
		logic             done;
		logic [ROW_W-1:0] row_number;
		logic             last_row;
	} row_tag_t;

endpackage

### hdl/qmv_if.sv
// interfaces: input word, result word and configuration write channels
`timescale 1ns / 1ps
interface qmv_item_if;
	import qmv_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   mode;
	logic [CHUNK_IDX_W-1:0] chunk_index;
	logic signed [LANE_W-1:0] lane0;
	logic signed [LANE_W-1:0] lane1;
	logic signed [LANE_W-1:0] lane2;
	logic signed [LANE_W-1:0] lane3;
	logic signed [LANE_W-1:0] lane4;
	logic signed [LANE_W-1:0] lane5;
	logic signed [LANE_W-1:0] lane6;
	logic signed [LANE_W-1:0] lane7;
	modport source (output valid, mode, chunk_index, lane0, lane1, lane2, lane3,
		lane4, lane5, lane6, lane7, input ready);
	modport sink (input valid, mode, chunk_index, lane0, lane1, lane2, lane3,
		lane4, lane5, lane6, lane7, output ready);
endinterface

interface qmv_result_if;
	import qmv_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [LANE_W-1:0] row_result;
	logic                     saturated;
	logic [ROW_W-1:0]         row_number;
	logic                     last_row;
	modport source (output valid, row_result, saturated, row_number, last_row, input ready);
	modport sink (input valid, row_result, saturated, row_number, last_row, output ready);
endinterface

interface qmv_cfg_if;
	import qmv_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/qmv_front.sv
// front end: input register, vector store, chunk and row counters, lane multipliers
`timescale 1ns / 1ps
module qmv_front (
	input  logic                                      clk,
	input  logic                                      arst_n,
	qmv_item_if.sink                                  item,
	input  qmv_pkg::cfg_t                             cfg,
	input  logic                                      next_ready,
	output logic                                      s2_valid,
	output qmv_pkg::prod_t [qmv_pkg::LANES-1:0]       prod_s2,
	output qmv_pkg::row_tag_t                         tag_s2
);
	import qmv_pkg::*;

	logic                   v_s1;
	logic                   mode_s1;
	logic [CHUNK_IDX_W-1:0] idx_s1;
	chunk_t                 lanes_s1;
	chunk_t                 store_q [CHUNKS_MAX];
	logic [CHUNK_IDX_W-1:0] chunk_cnt_q;
	logic [ROW_W-1:0]       row_q;

	logic                    accept;
	logic                    adv1;
	logic                    ready2;
	logic                    weight_go;
	logic [CHUNKS_CFG_W-1:0] eff_chunks;
	logic [CHUNKS_CFG_W-1:0] cnt_inc;
	logic [ROWS_CFG_W-1:0]   eff_rows;
	logic [ROWS_CFG_W-1:0]   row_inc;
	logic                    done;
	logic                    last;
	chunk_t                  entry;
	prod_t [LANES-1:0]       prod;

	assign ready2     = !s2_valid || next_ready;
	assign adv1       = v_s1 && (!mode_s1 || ready2);
	assign item.ready = !v_s1 || adv1;
	assign accept     = item.valid && item.ready;
	assign weight_go  = adv1 && mode_s1;

	always_comb begin
		priority if (cfg.chunks_per_row == '0) begin
			eff_chunks = CHUNKS_CFG_W'(1);
		end else if (cfg.chunks_per_row > CHUNKS_CFG_W'(CHUNKS_MAX)) begin
			eff_chunks = CHUNKS_CFG_W'(CHUNKS_MAX);
		end else begin
			eff_chunks = cfg.chunks_per_row;
		end
	end

	always_comb begin
		priority if (cfg.rows_per_tile == '0) begin
			eff_rows = ROWS_CFG_W'(1);
		end else if (cfg.rows_per_tile > ROWS_CFG_W'(ROWS_MAX)) begin
			eff_rows = ROWS_CFG_W'(ROWS_MAX);
		end else begin
			eff_rows = cfg.rows_per_tile;
		end
	end

	assign cnt_inc = CHUNKS_CFG_W'(chunk_cnt_q) + CHUNKS_CFG_W'(1);
	assign done    = cnt_inc >= eff_chunks;
	assign row_inc = ROWS_CFG_W'(row_q) + ROWS_CFG_W'(1);
	assign last    = row_inc >= eff_rows;
	assign entry   = store_q[chunk_cnt_q];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			prod[i] = $signed(lanes_s1[i]) * $signed(entry[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= item.mode;
			idx_s1   <= item.chunk_index;
			lanes_s1 <= {item.lane7, item.lane6, item.lane5, item.lane4,
				item.lane3, item.lane2, item.lane1, item.lane0};
		end
	end

	// vector store, no reset
	always_ff @(posedge clk) begin
		if (adv1 && !mode_s1) begin
			store_q[idx_s1] <= lanes_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_cnt_q <= '0;
			row_q       <= '0;
		end else if (weight_go) begin
			if (done) begin
				chunk_cnt_q <= '0;
				row_q       <= last ? '0 : row_inc[ROW_W-1:0];
			end else begin
				chunk_cnt_q <= cnt_inc[CHUNK_IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (ready2) begin
			s2_valid <= weight_go;
		end
	end

	always_ff @(posedge clk) begin
		if (ready2 && weight_go) begin
			prod_s2 <= prod;
			tag_s2  <= '{done: done, row_number: row_q, last_row: last};
		end
	end

endmodule

### hdl/qmv_sum.sv
// chunk sum stage: adds the eight lane products of one weight word
`timescale 1ns / 1ps
module qmv_sum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  qmv_pkg::prod_t [qmv_pkg::LANES-1:0] prod_s2,
	input  qmv_pkg::row_tag_t                   tag_s2,
	input  logic                                take,
	output logic                                in_ready,
	output logic                                s3_valid,
	output qmv_pkg::sum_t                       sum_s3,
	output qmv_pkg::row_tag_t                   tag_s3
);
	import qmv_pkg::*;

	sum_t sum;

	assign in_ready = !s3_valid || take;

	always_comb begin
		sum = '0;
		for (int i = 0; i < LANES; i++) begin
			sum = sum + {{(SUM_W-PROD_W){prod_s2[i][PROD_W-1]}}, prod_s2[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid <= 1'b0;
		end else if (in_ready) begin
			s3_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sum_s3 <= sum;
			tag_s3 <= tag_s2;
		end
	end

endmodule

### hdl/qmv_acc.sv
// row accumulator, shift and saturation, result register
`timescale 1ns / 1ps
module qmv_acc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s3_valid,
	input  qmv_pkg::sum_t     sum_s3,
	input  qmv_pkg::row_tag_t tag_s3,
	output logic              take,
	qmv_result_if.source      result
);
	import qmv_pkg::*;

	acc_t acc_q;
	logic out_valid_q;

	logic                     out_free;
	logic                     fire;
	acc_t                     total;
	acc_t                     shifted;
	logic signed [LANE_W-1:0] clipped;
	logic                     sat;

	assign out_free = !out_valid_q || result.ready;
	assign take     = !tag_s3.done || out_free;
	assign fire     = s3_valid && take;
	assign total    = acc_q + {{(ACC_W-SUM_W){sum_s3[SUM_W-1]}}, sum_s3};
	assign shifted  = total >>> FRACTION_SHIFT;

	always_comb begin
		priority if (shifted > $signed(ACC_W'(RES_MAX))) begin
			clipped = LANE_W'(RES_MAX);
			sat     = 1'b1;
		end else if (shifted < $signed(ACC_W'(RES_MIN))) begin
			clipped = LANE_W'(RES_MIN);
			sat     = 1'b1;
		end else begin
			clipped = shifted[LANE_W-1:0];
			sat     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (fire) begin
			acc_q <= tag_s3.done ? '0 : total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && tag_s3.done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && tag_s3.done) begin
			result.row_result <= clipped;
			result.saturated  <= sat;
			result.row_number <= tag_s3.row_number;
			result.last_row   <= tag_s3.last_row;
		end
	end

	assign result.valid = out_valid_q;

endmodule

### hdl/q15_matrix_vector_multiply.sv
// top level: q15 matrix-vector multiply with config registers
//
// item carries one word of eight Q1.15 lanes. mode 0 writes the lanes into
// vector store entry chunk_index; mode 1 is the next weight chunk of the
// current row and is multiplied lane by lane with the vector chunk at the
// running chunk count, the eight products added into the row accumulator.
// After chunks_per_row weight words (0 taken as 1, above 16 as 16) the row
// sum is shifted right by 15, saturated and sent on result with the row
// number and a last-row mark. cfg writes chunks_per_row (index 0) and
// rows_per_tile (index 1); it is always ready. It is to be written only
// while the pipeline is empty; the user is bound by this, the block does not enforce it.
// Throughput: one word per cycle while result does not stall. A row's
// result goes through the product, sum and result registers in turn.
// Reset clears the counters and the accumulator and loads 16 and 32 into the
// registers; vector store entries hold nothing until written.
// While result is stalled, weight words that do not end a row keep flowing
// into the accumulator; a row-ending word waits in the sum stage and item
// stalls once the stages behind it are full.
`timescale 1ns / 1ps
module q15_matrix_vector_multiply (
	input  logic         clk,
	input  logic         arst_n,
	qmv_item_if.sink     item,
	qmv_result_if.source result,
	qmv_cfg_if.sink      cfg
);
	import qmv_pkg::*;

	cfg_t              cfg_q;
	logic              s2_valid;
	prod_t [LANES-1:0] prod_s2;
	row_tag_t          tag_s2;
	logic              sum_ready;
	logic              s3_valid;
	sum_t              sum_s3;
	row_tag_t          tag_s3;
	logic              take;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chunks_per_row <= CHUNKS_RESET;
			cfg_q.rows_per_tile  <= ROWS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_CHUNKS_PER_ROW: begin
					cfg_q.chunks_per_row <= cfg.data[CHUNKS_CFG_W-1:0];
				end
				CFG_ROWS_PER_TILE: begin
					cfg_q.rows_per_tile <= cfg.data[ROWS_CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	qmv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg        (cfg_q),
		.next_ready (sum_ready),
		.s2_valid   (s2_valid),
		.prod_s2    (prod_s2),
		.tag_s2     (tag_s2)
	);

	qmv_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s2_valid),
		.prod_s2  (prod_s2),
		.tag_s2   (tag_s2),
		.take     (take),
		.in_ready (sum_ready),
		.s3_valid (s3_valid),
		.sum_s3   (sum_s3),
		.tag_s3   (tag_s3)
	);

	qmv_acc u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.s3_valid (s3_valid),
		.sum_s3   (sum_s3),
		.tag_s3   (tag_s3),
		.take     (take),
		.result   (result)
	);

endmodule
